@@ rtl/slc_pkg.sv @@
`timescale 1ns / 1ps

package slc_pkg;

    // One payload byte of a NAL unit, with the unit type and framing marks.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] nal_type;
        logic       first_of_unit;
        logic       last_of_unit;
    } t_in_word;

    // One classification result, given at the last byte of a unit.
    typedef struct packed {
        logic [2:0]  frame_class;
        logic [31:0] first_mb_value;
        logic [31:0] slice_type_value;
    } t_out_word;

    typedef enum logic [2:0] {
        CLS_P    = 3'd0,
        CLS_B    = 3'd1,
        CLS_I    = 3'd2,
        CLS_SEI  = 3'd3,
        CLS_SPS  = 3'd4,
        CLS_PPS  = 3'd5,
        CLS_NONE = 3'd6
    } t_frame_class;

    typedef enum logic [2:0] {
        PH_PRE1 = 3'd0,
        PH_SUF1 = 3'd1,
        PH_PRE2 = 3'd2,
        PH_SUF2 = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    localparam logic [4:0] NAL_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_IDR     = 5'd5;
    localparam logic [4:0] NAL_SEI     = 5'd6;
    localparam logic [4:0] NAL_SPS     = 5'd7;
    localparam logic [4:0] NAL_PPS     = 5'd8;

    localparam logic [3:0] SLICE_P      = 4'd0;
    localparam logic [3:0] SLICE_B      = 4'd1;
    localparam logic [3:0] SLICE_I      = 4'd2;
    localparam logic [3:0] SLICE_SP     = 4'd3;
    localparam logic [3:0] SLICE_SI     = 4'd4;
    localparam logic [3:0] SLICE_P_ALL  = 4'd5;
    localparam logic [3:0] SLICE_B_ALL  = 4'd6;
    localparam logic [3:0] SLICE_I_ALL  = 4'd7;
    localparam logic [3:0] SLICE_SP_ALL = 4'd8;
    localparam logic [3:0] SLICE_SI_ALL = 4'd9;

    // Both codes of a finished unit in raw form: prefix length and suffix.
    // The code value is (2^z - 1) + suffix, taken modulo 2^32.
    typedef struct packed {
        logic [4:0]  nal_type;
        logic [5:0]  mb_z;
        logic [31:0] mb_a;
        logic [5:0]  st_z;
        logic [31:0] st_a;
    } t_code_raw;

endpackage

@@ rtl/h264_slice_type_classifier.sv @@
`timescale 1ns / 1ps

// Classifies H.264 NAL units from the payload bytes that follow the header.
// Input channel: one word per byte (i_valid / o_ready), carrying the byte, the
// unit type and first/last marks. The type is taken from the first word of a
// unit. Output channel: one word per unit (o_valid / i_ready), given after the
// word marked last, with the frame class and the two decoded Exp-Golomb codes.
// Throughput is one input word per cycle while o_ready is high; the eight
// bits of a byte are parsed together in the parse stage. The three register
// stages are the input register, the parse stage and the result register.
// Reset clears the parse state, the held unit type and all valid flags.
// When the receiver stalls, the finished result stays in the output register
// and one more finished unit can wait in the parse stage; words that close no
// unit keep flowing, and o_ready falls only when a last word cannot move on.

module h264_slice_type_classifier #(
    parameter int MAX_PREFIX = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  slc_pkg::t_in_word  i_in_word,
    output logic               o_valid,
    input  logic               i_ready,
    output slc_pkg::t_out_word o_out_word
);
    import slc_pkg::*;

    logic      r_in_valid, n_in_valid;
    t_in_word  r_in_word;
    logic      take;
    logic      raw_valid;
    logic      raw_ready;
    t_code_raw raw;

    assign o_ready    = !r_in_valid || take;
    assign n_in_valid = (i_valid && o_ready) || (r_in_valid && !take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_word <= i_in_word;
        end
    end

    slc_parser #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_word  (r_in_word),
        .o_take  (take),
        .o_valid (raw_valid),
        .i_ready (raw_ready),
        .o_raw   (raw)
    );

    slc_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (raw_valid),
        .i_raw   (raw),
        .o_ready (raw_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_out_word)
    );

endmodule

@@ rtl/slc_parser.sv @@
`timescale 1ns / 1ps

module slc_parser #(
    parameter int MAX_PREFIX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  slc_pkg::t_in_word i_word,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output slc_pkg::t_code_raw o_raw
);
    import slc_pkg::*;

    localparam logic [5:0] CAP = 6'(MAX_PREFIX);

    typedef struct packed {
        t_phase      phase;
        logic [5:0]  zero_run;
        logic [5:0]  left;
        logic [31:0] accum;
        logic [5:0]  mb_z;
        logic [31:0] mb_a;
    } t_parse;

    t_parse    r_st, n_st;
    logic [4:0] r_type, n_type;
    logic      r_valid, n_valid;
    t_code_raw r_raw, n_raw;

    t_parse     s_byte;
    logic [4:0] cur_type;
    logic       go;

    // Closes the current code with prefix length z and suffix a.
    function automatic t_parse finish(t_parse s, logic [5:0] z, logic [31:0] a);
        t_parse n;
        n      = s;
        n.left = '0;
        if (s.phase == PH_PRE1 || s.phase == PH_SUF1) begin
            n.mb_z     = z;
            n.mb_a     = a;
            n.phase    = PH_PRE2;
            n.zero_run = '0;
            n.accum    = '0;
        end else begin
            // The second code stays in zero_run and accum once done.
            n.zero_run = z;
            n.accum    = a;
            n.phase    = PH_DONE;
        end
        return n;
    endfunction

    function automatic t_parse step_bit(t_parse s, logic b);
        t_parse      n;
        logic [5:0]  zr_inc;
        logic [5:0]  left_dec;
        logic [31:0] acc_sh;
        n        = s;
        zr_inc   = s.zero_run + 6'd1;
        left_dec = s.left - 6'd1;
        acc_sh   = {s.accum[30:0], b};
        case (s.phase)
            PH_PRE1, PH_PRE2: begin
                if (b) begin
                    if (s.zero_run == '0) begin
                        n = finish(s, '0, '0);
                    end else begin
                        n.left  = s.zero_run;
                        n.accum = '0;
                        n.phase = (s.phase == PH_PRE1) ? PH_SUF1 : PH_SUF2;
                    end
                end else begin
                    n.zero_run = zr_inc;
                    // A capped prefix ends without a terminating one.
                    if (zr_inc >= CAP) begin
                        n.left  = zr_inc;
                        n.accum = '0;
                        n.phase = (s.phase == PH_PRE1) ? PH_SUF1 : PH_SUF2;
                    end
                end
            end
            PH_SUF1, PH_SUF2: begin
                n.accum = acc_sh;
                n.left  = left_dec;
                if (left_dec == '0) begin
                    n = finish(s, s.zero_run, acc_sh);
                end
            end
            default: begin
                n = s;
            end
        endcase
        return n;
    endfunction

    always_comb begin
        s_byte   = i_word.first_of_unit ? t_parse'('0) : r_st;
        cur_type = i_word.first_of_unit ? i_word.nal_type : r_type;
        for (int i = 0; i < 8; i++) begin
            s_byte = step_bit(s_byte, i_word.data_byte[7 - i]);
        end

        // Bits past the end of the unit read as zero; the outcome of that
        // zero fill depends only on where the parse stands.
        n_raw.nal_type = cur_type;
        n_raw.mb_z     = s_byte.mb_z;
        n_raw.mb_a     = s_byte.mb_a;
        n_raw.st_z     = CAP;
        n_raw.st_a     = '0;
        case (s_byte.phase)
            PH_PRE1: begin
                n_raw.mb_z = CAP;
                n_raw.mb_a = '0;
            end
            PH_SUF1: begin
                n_raw.mb_z = s_byte.zero_run;
                n_raw.mb_a = s_byte.accum << s_byte.left;
            end
            PH_PRE2: begin
                n_raw.st_z = CAP;
            end
            PH_SUF2: begin
                n_raw.st_z = s_byte.zero_run;
                n_raw.st_a = s_byte.accum << s_byte.left;
            end
            default: begin
                n_raw.st_z = s_byte.zero_run;
                n_raw.st_a = s_byte.accum;
            end
        endcase

        go      = i_valid && (!i_word.last_of_unit || !r_valid || i_ready);
        n_valid = (go && i_word.last_of_unit) || (r_valid && !i_ready);
        n_st    = r_st;
        n_type  = r_type;
        if (go) begin
            n_st   = i_word.last_of_unit ? t_parse'('0) : s_byte;
            n_type = cur_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_type  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_type  <= n_type;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && i_word.last_of_unit) begin
            r_raw <= n_raw;
        end
    end

    assign o_take  = go;
    assign o_valid = r_valid;
    assign o_raw   = r_raw;

endmodule

@@ rtl/slc_result.sv @@
`timescale 1ns / 1ps

module slc_result (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  slc_pkg::t_code_raw i_raw,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output slc_pkg::t_out_word o_word
);
    import slc_pkg::*;

    logic         r_valid, n_valid;
    t_out_word    r_word, n_word;
    logic         take;
    logic [31:0]  mb_val;
    logic [31:0]  st_val;
    t_frame_class cls;

    always_comb begin
        // A code with z leading zeros is worth 2^z - 1 plus its suffix.
        mb_val = ~(32'hFFFF_FFFF << i_raw.mb_z) + i_raw.mb_a;
        st_val = ~(32'hFFFF_FFFF << i_raw.st_z) + i_raw.st_a;

        cls = CLS_NONE;
        if (i_raw.nal_type == NAL_NON_IDR || i_raw.nal_type == NAL_IDR) begin
            if (st_val[31:4] == '0) begin
                unique case (st_val[3:0]) inside
                    SLICE_P, SLICE_SP, SLICE_P_ALL, SLICE_SP_ALL: cls = CLS_P;
                    SLICE_B, SLICE_B_ALL:                         cls = CLS_B;
                    SLICE_I, SLICE_SI, SLICE_I_ALL, SLICE_SI_ALL: cls = CLS_I;
                    default:                                      cls = CLS_NONE;
                endcase
            end
        end else if (i_raw.nal_type == NAL_SEI) begin
            cls = CLS_SEI;
        end else if (i_raw.nal_type == NAL_SPS) begin
            cls = CLS_SPS;
        end else if (i_raw.nal_type == NAL_PPS) begin
            cls = CLS_PPS;
        end

        n_word.frame_class = cls;
        if (i_raw.nal_type == NAL_NON_IDR || i_raw.nal_type == NAL_IDR) begin
            n_word.first_mb_value   = mb_val;
            n_word.slice_type_value = st_val;
        end else begin
            n_word.first_mb_value   = '0;
            n_word.slice_type_value = '0;
        end

        take    = i_valid && (!r_valid || i_ready);
        n_valid = take || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
